// ----- rtl/core/swrs_pkg.sv -----
// Package with shared constants and types for the stripe window request splitter.
`default_nettype none
package swrs_pkg;
   localparam int MaxServers = 4;
   localparam logic [23:0] MaxWindowTotal = 24'd10485760;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_NEXT  = 2'd1;
   localparam logic [1:0] CMD_DONE  = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_WINDOW  = 3'd1;
   localparam logic [2:0] ST_REQUEST = 3'd2;
   localparam logic [2:0] ST_BADSRV  = 3'd3;
   localparam logic [2:0] ST_NOLAY   = 3'd4;
   localparam logic [2:0] ST_NOTHING = 3'd5;

   localparam logic [1:0] MODE_NULL = 2'd0;
   localparam logic [1:0] MODE_PEND = 2'd1;
   localparam logic [1:0] MODE_SENT = 2'd2;
   localparam logic [1:0] MODE_RECV = 2'd3;

   localparam logic [2:0] REG_COUNT  = 3'd0;
   localparam logic [2:0] REG_SS0    = 3'd1;
   localparam logic [2:0] REG_SS1    = 3'd2;
   localparam logic [2:0] REG_SS2    = 3'd3;
   localparam logic [2:0] REG_SS3    = 3'd4;
   localparam logic [2:0] REG_OFFSET = 3'd5;
   localparam logic [2:0] REG_LENGTH = 3'd6;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  done_server;
      logic [23:0] done_size;
   } req_type;

   typedef struct packed {
      logic        share_valid;
      logic [1:0]  share_server;
      logic [39:0] share_offset;
      logic [23:0] share_size;
      logic [23:0] window_bytes;
      logic [2:0]  status;
   } rsp_type;
endpackage
`default_nettype wire

// ----- rtl/core/swrs_if.sv -----
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface swrs_req_if;
   logic               valid;
   logic               ready;
   swrs_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface swrs_rsp_if;
   logic               valid;
   logic               ready;
   swrs_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/stripe_window_request_splitter_top.sv -----
// Top level of the stripe window request splitter with its sequencer and shared unit.
// The block splits a striped file request across up to four data servers.
// The req channel carries commands: start, next share, and completion.
// Every accepted req transfer gives exactly one rsp transfer.
// Write the registers over the csr APB port only while idle; the block does not check.
// A start divides the request offset by the stripe sum with a restoring
// divider, one quotient bit per cycle, then places the servers and fills
// the first window; window fill divides the window left by the stripe sum
// with the same divider. A next share that finds no pending share first tries
// to open a new window, which it does if no share is out and bytes remain.
// One item is handled at a time; req.ready is low from acceptance until the
// result has been handed to the output register and is high again right after.
// The output register holds a result until rsp.ready; while it is full and
// not taken, a further result waits in the sequencer.
// Synchronous reset clears the control, slot and window state; registers go to defaults.
`default_nettype none
module stripe_window_request_splitter_top (
   input  wire logic          clock,
   input  wire logic          reset,
   swrs_req_if.sink           req,
   swrs_rsp_if.source         rsp,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [5:0]    csr_paddr,
   input  wire logic [63:0]   csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);
   import swrs_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DIV    = 4'd1;
   localparam logic [3:0] S_PLACE  = 4'd2;
   localparam logic [3:0] S_OPEN   = 4'd3;
   localparam logic [3:0] S_R1     = 4'd4;
   localparam logic [3:0] S_WDIV   = 4'd5;
   localparam logic [3:0] S_KADD   = 4'd6;
   localparam logic [3:0] S_R2     = 4'd7;
   localparam logic [3:0] S_SLOTS  = 4'd8;
   localparam logic [3:0] S_ISSUE  = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;
   localparam logic [3:0] S_MUL    = 4'd11;

   logic [2:0]  count_ff;
   logic [23:0] stripe_ff [MaxServers];
   logic [39:0] roff_ff, rlen_ff;

   logic [25:0] slot_ff [MaxServers];
   logic [39:0] soff_ff [MaxServers];
   logic [39:0] remain_ff;
   logic [23:0] wtotal_ff, fpos_ff;
   logic [1:0]  fserver_ff;
   logic        loaded_ff;

   logic [3:0]  state_ff;
   logic [1:0]  cmd_ff;
   logic [2:0]  ds_ff;
   logic [23:0] dsz_ff;
   logic        started_ff;
   logic        retry_ff;
   logic        placed_ff;
   logic [5:0]  cnt_ff;
   logic [1:0]  idx_ff;
   logic [2:0]  step_ff;
   logic [39:0] quo_ff;
   logic [40:0] rem_ff;
   logic [39:0] left_ff;
   logic [39:0] alloc_ff [MaxServers];
   rsp_type     res_ff;
   logic        outv_ff;
   rsp_type     obuf_ff;

   logic [2:0]  n_eff;
   logic [25:0] sum;
   logic [1:0]  f_eff;
   logic [1:0]  rot_idx;
   logic [40:0] trial;
   logic [39:0] amt;
   logic [63:0] prod;
   logic        any_sent;
   logic        any_open;
   logic [2:0]  pend_idx;
   rsp_type     nolay_rsp;
   rsp_type     share_rsp;
   rsp_type     res_out;

   assign n_eff = (count_ff > 3'd4) ? 3'd4 : count_ff;

   always_comb begin
      sum = '0;
      for (int i = 0; i < MaxServers; i++) begin
         if (3'(i) < n_eff) begin
            sum = sum + {2'b00, stripe_ff[i]};
         end
      end
      any_sent = 1'b0;
      any_open = 1'b0;
      pend_idx = 3'd4;
      for (int i = MaxServers - 1; i >= 0; i--) begin
         if (3'(i) < n_eff) begin
            if (slot_ff[i][25:24] == MODE_SENT) begin
               any_sent = 1'b1;
            end
            if (slot_ff[i][25:24] == MODE_PEND || slot_ff[i][25:24] == MODE_SENT) begin
               any_open = 1'b1;
            end
            if (slot_ff[i][25:24] == MODE_PEND) begin
               pend_idx = 3'(i);
            end
         end
      end
   end

   assign f_eff = ({1'b0, fserver_ff} < n_eff) ? fserver_ff : 2'd0;

   always_comb begin
      logic [2:0] s;
      s = {1'b0, f_eff} + step_ff;
      if (s >= n_eff) begin
         s = s - n_eff;
      end
      rot_idx = s[1:0];
   end

   assign trial = {rem_ff[39:0], quo_ff[39]} - {15'd0, sum};
   assign prod  = {24'd0, quo_ff} * {40'd0, stripe_ff[idx_ff]};

   always_comb begin
      amt = {16'd0, stripe_ff[rot_idx]};
      if (state_ff == S_R1 && step_ff == 3'd0) begin
         amt = (stripe_ff[rot_idx] > fpos_ff) ? {16'd0, stripe_ff[rot_idx] - fpos_ff} : 40'd0;
      end
   end

   always_comb begin
      nolay_rsp = '0;
      nolay_rsp.status = ST_NOLAY;
      share_rsp = '0;
      share_rsp.share_valid = 1'b1;
      share_rsp.share_server = pend_idx[1:0];
      share_rsp.share_offset = soff_ff[pend_idx[1:0]];
      share_rsp.share_size = slot_ff[pend_idx[1:0]][23:0];
      res_out = res_ff;
      res_out.window_bytes = wtotal_ff;
   end

   assign req.ready  = (state_ff == S_IDLE) && !reset;
   assign rsp.valid  = outv_ff;
   assign rsp.data   = obuf_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[5:3])
         REG_COUNT:  csr_prdata = {61'd0, count_ff};
         REG_SS0:    csr_prdata = {40'd0, stripe_ff[0]};
         REG_SS1:    csr_prdata = {40'd0, stripe_ff[1]};
         REG_SS2:    csr_prdata = {40'd0, stripe_ff[2]};
         REG_SS3:    csr_prdata = {40'd0, stripe_ff[3]};
         REG_OFFSET: csr_prdata = {24'd0, roff_ff};
         REG_LENGTH: csr_prdata = {24'd0, rlen_ff};
         default:    csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd1;
         for (int i = 0; i < MaxServers; i++) begin
            stripe_ff[i] <= 24'd65536;
         end
         roff_ff <= '0;
         rlen_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[5:3])
            REG_COUNT:  count_ff <= csr_pwdata[2:0];
            REG_SS0:    stripe_ff[0] <= csr_pwdata[23:0];
            REG_SS1:    stripe_ff[1] <= csr_pwdata[23:0];
            REG_SS2:    stripe_ff[2] <= csr_pwdata[23:0];
            REG_SS3:    stripe_ff[3] <= csr_pwdata[23:0];
            REG_OFFSET: roff_ff <= csr_pwdata[39:0];
            REG_LENGTH: rlen_ff <= csr_pwdata[39:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outv_ff <= 1'b0;
      end else if (state_ff == S_OUT && (!outv_ff || rsp.ready)) begin
         outv_ff <= 1'b1;
         obuf_ff <= res_out;
      end else if (rsp.ready) begin
         outv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         loaded_ff  <= 1'b0;
         remain_ff  <= '0;
         wtotal_ff  <= '0;
         fpos_ff    <= '0;
         fserver_ff <= '0;
         for (int i = 0; i < MaxServers; i++) begin
            slot_ff[i] <= '0;
            soff_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  cmd_ff  <= req.data.command;
                  ds_ff   <= req.data.done_server;
                  dsz_ff  <= req.data.done_size;
                  retry_ff <= 1'b0;
                  started_ff <= 1'b0;
                  case (req.data.command)
                     CMD_START: begin
                        if (n_eff == 3'd0 || sum == 26'd0) begin
                           loaded_ff <= 1'b0;
                           res_ff <= nolay_rsp;
                           state_ff <= S_OUT;
                        end else begin
                           res_ff <= '0;
                           quo_ff <= roff_ff;
                           rem_ff <= '0;
                           cnt_ff <= 6'd40;
                           state_ff <= S_DIV;
                        end
                     end
                     CMD_NEXT: begin
                        if (!loaded_ff || n_eff == 3'd0 || sum == 26'd0) begin
                           res_ff <= nolay_rsp;
                           state_ff <= S_OUT;
                        end else begin
                           res_ff <= '0;
                           state_ff <= S_ISSUE;
                        end
                     end
                     CMD_DONE: begin
                        res_ff <= '0;
                        state_ff <= S_SLOTS;
                     end
                     default: begin
                        res_ff <= '0;
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_DIV: begin
               if (!trial[40]) begin
                  rem_ff <= trial;
                  quo_ff <= {quo_ff[38:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[39:0], quo_ff[39]};
                  quo_ff <= {quo_ff[38:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  idx_ff <= '0;
                  placed_ff <= 1'b0;
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               // quo_ff holds jumps, rem_ff the remainder; one server per cycle.
               if ({1'b0, idx_ff} < n_eff) begin
                  if (!placed_ff && rem_ff[39:0] <= {16'd0, stripe_ff[idx_ff]}) begin
                     fserver_ff <= idx_ff;
                     fpos_ff <= rem_ff[23:0];
                     soff_ff[idx_ff] <= prod[39:0] + rem_ff[39:0];
                     placed_ff <= 1'b1;
                  end else if (!placed_ff) begin
                     soff_ff[idx_ff] <= prod[39:0] + {16'd0, stripe_ff[idx_ff]};
                     rem_ff <= rem_ff - {17'd0, stripe_ff[idx_ff]};
                  end else begin
                     soff_ff[idx_ff] <= prod[39:0];
                  end
               end else begin
                  soff_ff[idx_ff] <= '0;
               end
               slot_ff[idx_ff] <= '0;
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'(MaxServers - 1)) begin
                  loaded_ff <= 1'b1;
                  remain_ff <= rlen_ff;
                  wtotal_ff <= '0;
                  started_ff <= 1'b1;
                  state_ff <= S_OPEN;
               end
            end
            S_OPEN: begin
               if (any_sent || remain_ff == 40'd0) begin
                  if (started_ff && cmd_ff == CMD_START) begin
                     res_ff.status <= ST_REQUEST;
                  end else begin
                     res_ff.status <= ST_NOTHING;
                  end
                  state_ff <= S_OUT;
               end else begin
                  if (remain_ff > {16'd0, MaxWindowTotal}) begin
                     wtotal_ff <= MaxWindowTotal;
                     left_ff <= {16'd0, MaxWindowTotal};
                     remain_ff <= remain_ff - {16'd0, MaxWindowTotal};
                  end else begin
                     wtotal_ff <= remain_ff[23:0];
                     left_ff <= remain_ff;
                     remain_ff <= '0;
                  end
                  for (int i = 0; i < MaxServers; i++) begin
                     slot_ff[i] <= '0;
                     alloc_ff[i] <= '0;
                  end
                  step_ff <= '0;
                  state_ff <= S_R1;
               end
            end
            S_R1, S_R2: begin
               if (step_ff < n_eff && left_ff != 40'd0) begin
                  if (amt < left_ff) begin
                     alloc_ff[rot_idx] <= alloc_ff[rot_idx] + amt;
                     left_ff <= left_ff - amt;
                  end else begin
                     alloc_ff[rot_idx] <= alloc_ff[rot_idx] + left_ff;
                     left_ff <= '0;
                  end
                  step_ff <= step_ff + 3'd1;
               end else if (state_ff == S_R1 && left_ff != 40'd0) begin
                  quo_ff <= {left_ff[23:0], 16'd0};
                  rem_ff <= '0;
                  cnt_ff <= 6'd24;
                  state_ff <= S_WDIV;
               end else begin
                  for (int i = 0; i < MaxServers; i++) begin
                     if (3'(i) < n_eff && alloc_ff[i] != 40'd0) begin
                        slot_ff[i] <= {MODE_PEND, alloc_ff[i][23:0]};
                     end
                  end
                  if (cmd_ff == CMD_START) begin
                     state_ff <= S_OUT;
                  end else begin
                     retry_ff <= 1'b1;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_WDIV: begin
               if (!trial[40]) begin
                  rem_ff <= trial;
                  quo_ff <= {quo_ff[38:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[39:0], quo_ff[39]};
                  quo_ff <= {quo_ff[38:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  idx_ff <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               quo_ff <= {16'd0, quo_ff[23:0]};
               left_ff <= rem_ff[39:0];
               state_ff <= S_KADD;
            end
            S_KADD: begin
               if ({1'b0, idx_ff} < n_eff) begin
                  alloc_ff[idx_ff] <= alloc_ff[idx_ff] + prod[39:0];
               end
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'(MaxServers - 1)) begin
                  step_ff <= '0;
                  state_ff <= S_R2;
               end
            end
            S_ISSUE: begin
               if (pend_idx != 3'd4) begin
                  res_ff <= share_rsp;
                  slot_ff[pend_idx[1:0]][25:24] <= MODE_SENT;
                  state_ff <= S_OUT;
               end else if (retry_ff) begin
                  res_ff.status <= ST_NOTHING;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_OPEN;
               end
            end
            S_SLOTS: begin
               if (ds_ff >= n_eff) begin
                  res_ff.status <= ST_BADSRV;
                  state_ff <= S_OUT;
               end else if (!retry_ff) begin
                  slot_ff[ds_ff[1:0]] <= {MODE_RECV, 24'd0};
                  soff_ff[ds_ff[1:0]] <= soff_ff[ds_ff[1:0]] + {16'd0, dsz_ff};
                  retry_ff <= 1'b1;
               end else begin
                  if (any_open) begin
                     res_ff.status <= ST_OK;
                  end else begin
                     res_ff.status <= (remain_ff == 40'd0) ? ST_REQUEST : ST_WINDOW;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!outv_ff || rsp.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("second transfer accepted during work");
   a_share_status: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data.share_valid) |-> rsp.data.status == ST_OK)
      else $error("share issued with error status");
   a_window_bound: assert property (@(posedge clock) disable iff (reset)
      wtotal_ff <= MaxWindowTotal)
      else $error("window above maximum");
`endif
endmodule
`default_nettype wire
